/* hdl/rrm_pkg.sv */
// Package with shared constants, types and a helper function for the row rank mask block.
`timescale 1ns / 1ps

package rrm_pkg;

    localparam int ROW_MAX = 64;
    localparam int IDX_W   = $clog2(ROW_MAX);
    localparam int LEN_W   = 7;
    localparam int RANK_W  = 6;
    localparam int COEF_W  = 16;
    localparam int MAG_W   = COEF_W - 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = LEN_W;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_LEN    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANK_INDEX = 1'd1;

    localparam logic [LEN_W-1:0] ROW_LEN_RST = 7'd64;

    // Insertion request broadcast to every cell of the sorting chain.
    typedef struct packed {
        logic             valid;
        logic             restart;
        logic [MAG_W-1:0] mag;
    } ins_t;

    // What a cell shows its right-hand neighbor.
    typedef struct packed {
        logic             occ;
        logic             gt;
        logic [MAG_W-1:0] mag;
    } link_t;

    // Saturated magnitude: the most negative value maps to the largest magnitude.
    function automatic logic [MAG_W-1:0] magnitude(input logic [COEF_W-1:0] v);
        logic [COEF_W-1:0] neg;
        neg = COEF_W'(~v + COEF_W'(1));
        if (!v[COEF_W-1])
            return v[MAG_W-1:0];
        else if (neg[COEF_W-1])
            return '1;
        else
            return neg[MAG_W-1:0];
    endfunction

endpackage

/* hdl/rrm_ifs.sv */
// Valid/ready channel interfaces for coefficients in and masked coefficients out.
`timescale 1ns / 1ps

interface rrm_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [rrm_pkg::COEF_W-1:0] coeff_in;

    modport source (output valid, output coeff_in, input ready);
    modport sink   (input valid, input coeff_in, output ready);
endinterface

interface rrm_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [rrm_pkg::COEF_W-1:0] coeff_out;
    logic                              row_end;

    modport source (output valid, output coeff_out, output row_end, input ready);
    modport sink   (input valid, input coeff_out, input row_end, output ready);
endinterface

/* hdl/row_rank_magnitude_mask.sv */
// Top level of the row rank magnitude mask: row store, sorting chain and result stream.
// Coefficients are taken one per cycle until a row of row_len values, clamped to 1..64,
// is held; each one is inserted into a 64-cell sorting chain as it arrives, so the
// rank_index-th smallest magnitude is ready once the row is complete. The ST_THR state
// then latches that threshold, and the row is read back from the row store in arrival
// order through rd_data_reg and out_data_reg, one result per cycle while the output is
// not stalled, with magnitudes below the threshold zeroed and row_end on the last value.
// No coefficient is taken while a row is being emitted. The row store needs no clearing
// after reset.
`timescale 1ns / 1ps

module row_rank_magnitude_mask
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rrm_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [rrm_pkg::CFG_DATA_W-1:0]      cfg_data,
    rrm_in_if.sink                              coeffs,
    rrm_out_if.source                           masked
);

    localparam logic [1:0] ST_FILL = 2'd0;
    localparam logic [1:0] ST_THR  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic [rrm_pkg::LEN_W-1:0]  row_len_reg;
    logic [rrm_pkg::RANK_W-1:0] rank_reg;
    logic [rrm_pkg::LEN_W-1:0]  fill_reg;
    logic [rrm_pkg::LEN_W-1:0]  fill_next;
    logic [rrm_pkg::LEN_W-1:0]  iss_reg;
    logic [rrm_pkg::LEN_W-1:0]  iss_next;
    logic [rrm_pkg::MAG_W-1:0]  thr_reg;
    logic                       rd_valid_reg;
    logic                       rd_valid_next;
    logic                       rd_last_reg;
    logic [rrm_pkg::COEF_W-1:0] rd_data_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [rrm_pkg::COEF_W-1:0] out_data_reg;
    logic                       out_last_reg;

    logic [rrm_pkg::COEF_W-1:0] row_store [rrm_pkg::ROW_MAX];

    logic [rrm_pkg::LEN_W-1:0]  eff_len;
    logic [rrm_pkg::LEN_W-1:0]  rank_clamped;
    logic [rrm_pkg::LEN_W-1:0]  fill_inc;
    logic                       accept_in;
    logic                       out_done;
    logic                       restart;
    logic [rrm_pkg::IDX_W-1:0]  wr_idx;
    logic                       issue;
    logic                       rd_move;
    logic                       rd_below;
    rrm_pkg::ins_t              ins;
    logic [rrm_pkg::MAG_W-1:0]  rank_mag;

    always_comb
    begin
        if (row_len_reg == '0)
            eff_len = rrm_pkg::LEN_W'(1);
        else if (row_len_reg > rrm_pkg::LEN_W'(rrm_pkg::ROW_MAX))
            eff_len = rrm_pkg::LEN_W'(rrm_pkg::ROW_MAX);
        else
            eff_len = row_len_reg;
    end

    assign rank_clamped = (rrm_pkg::LEN_W'(rank_reg) >= eff_len)
                        ? eff_len - rrm_pkg::LEN_W'(1)
                        : rrm_pkg::LEN_W'(rank_reg);

    assign coeffs.ready = (state_reg == ST_FILL);
    assign accept_in    = coeffs.valid && coeffs.ready;
    assign out_done     = masked.valid && masked.ready && masked.row_end;

    // A partial row left over from a longer row length is dropped here.
    assign restart  = (fill_reg == '0) || (fill_reg >= eff_len);
    assign wr_idx   = restart ? '0 : fill_reg[rrm_pkg::IDX_W-1:0];
    assign fill_inc = restart ? rrm_pkg::LEN_W'(1) : fill_reg + rrm_pkg::LEN_W'(1);

    assign ins.valid   = accept_in;
    assign ins.restart = restart;
    assign ins.mag     = rrm_pkg::magnitude(coeffs.coeff_in);

    rrm_sort_chain u_chain
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ins      (ins),
        .rank_sel (rank_clamped[rrm_pkg::IDX_W-1:0]),
        .rank_mag (rank_mag)
    );

    assign rd_move = rd_valid_reg && (!out_valid_reg || masked.ready);
    assign issue   = (state_reg == ST_EMIT) && (iss_reg < eff_len)
                   && (!rd_valid_reg || rd_move);
    assign rd_below = rrm_pkg::magnitude(rd_data_reg) < thr_reg;

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        iss_next   = iss_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                if (accept_in)
                begin
                    fill_next = fill_inc;
                    if (fill_inc == eff_len)
                        state_next = ST_THR;
                end
            end
            ST_THR:
            begin
                fill_next  = '0;
                iss_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (issue)
                    iss_next = iss_reg + rrm_pkg::LEN_W'(1);
                if (out_done)
                    state_next = ST_FILL;
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_comb
    begin
        rd_valid_next = rd_valid_reg;
        if (issue)
            rd_valid_next = 1'b1;
        else if (rd_move)
            rd_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (rd_move)
            out_valid_next = 1'b1;
        else if (masked.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            row_len_reg   <= rrm_pkg::ROW_LEN_RST;
            rank_reg      <= '0;
            fill_reg      <= '0;
            iss_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            iss_reg       <= iss_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    rrm_pkg::REG_ROW_LEN:    row_len_reg <= cfg_data;
                    rrm_pkg::REG_RANK_INDEX: rank_reg    <= cfg_data[rrm_pkg::RANK_W-1:0];
                    default:                 rank_reg    <= rank_reg;
                endcase
            end
        end
    end

    // Row store and its registered read port; data is captured only when a read issues.
    always_ff @(posedge clk)
    begin
        if (accept_in)
            row_store[wr_idx] <= coeffs.coeff_in;
        if (issue)
            rd_data_reg <= row_store[iss_reg[rrm_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_THR)
            thr_reg <= rank_mag;
        if (issue)
            rd_last_reg <= (iss_reg == eff_len - rrm_pkg::LEN_W'(1));
        if (rd_move)
        begin
            out_data_reg <= rd_below ? '0 : rd_data_reg;
            out_last_reg <= rd_last_reg;
        end
    end

    assign masked.valid     = out_valid_reg;
    assign masked.coeff_out = out_data_reg;
    assign masked.row_end   = out_last_reg;

endmodule

/* hdl/rrm_sort_cell.sv */
// One cell of the insertion sorting chain, holding a single magnitude.
`timescale 1ns / 1ps

module rrm_sort_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  rrm_pkg::ins_t       ins,
    input  rrm_pkg::link_t      left,
    output rrm_pkg::link_t      right
);

    logic                      valid_reg;
    logic                      valid_next;
    logic [rrm_pkg::MAG_W-1:0] mag_reg;
    logic [rrm_pkg::MAG_W-1:0] mag_next;
    logic                      occ;
    logic                      gt;
    logic [rrm_pkg::MAG_W-1:0] shift_in;

    // A restart empties the whole chain before the new value goes in.
    assign occ      = valid_reg && !(ins.valid && ins.restart);
    assign gt       = occ && (mag_reg > ins.mag);
    assign shift_in = left.gt ? left.mag : ins.mag;

    assign right.occ = occ;
    assign right.gt  = gt;
    assign right.mag = mag_reg;

    always_comb
    begin
        valid_next = valid_reg;
        mag_next   = mag_reg;
        if (ins.valid)
        begin
            valid_next = occ || left.occ;
            if (!occ || gt)
                mag_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
    end

endmodule

/* hdl/rrm_sort_chain.sv */
// Row of sorting cells that keeps the row's magnitudes in ascending order.
`timescale 1ns / 1ps

module rrm_sort_chain
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  rrm_pkg::ins_t               ins,
    input  logic [rrm_pkg::IDX_W-1:0]   rank_sel,
    output logic [rrm_pkg::MAG_W-1:0]   rank_mag
);

    rrm_pkg::link_t links [rrm_pkg::ROW_MAX];
    rrm_pkg::link_t head;

    // The left edge acts as an occupied cell that is never larger than the new value.
    assign head.occ = 1'b1;
    assign head.gt  = 1'b0;
    assign head.mag = '0;

    for (genvar i = 0; i < rrm_pkg::ROW_MAX; i++)
    begin : g_cell
        rrm_sort_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .ins   (ins),
            .left  ((i == 0) ? head : links[(i == 0) ? 0 : i - 1]),
            .right (links[i])
        );
    end

    assign rank_mag = links[rank_sel].mag;

endmodule

/* hdl/rrm_checker.sv */
// Port-level checks for the row rank magnitude mask, bound to the top level.
`timescale 1ns / 1ps

module rrm_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [rrm_pkg::COEF_W-1:0]        out_coeff,
    input logic                              out_end
);

    // Rows are collected and emitted in turn, never at the same time.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while results are pending");

    // Inside a row the results follow each other without a gap once taken.
    a_row_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_end) |=> out_valid)
        else $error("gap inside an emitted row");

    // After the last result of a row the block returns to collecting.
    a_row_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_end) |=> (!out_valid && in_ready))
        else $error("block did not return to collecting after row end");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_coeff) && $stable(out_end)))
        else $error("stalled result changed");

    a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid)
        else $error("transaction accepted during emission");

endmodule

bind row_rank_magnitude_mask rrm_checker u_rrm_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (coeffs.valid),
    .in_ready  (coeffs.ready),
    .out_valid (masked.valid),
    .out_ready (masked.ready),
    .out_coeff (masked.coeff_out),
    .out_end   (masked.row_end)
);
